// ===== sv/line_pixel_generator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Line pixel generator assertion macros
// Shared assertion helpers; every use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define LINE_PIXEL_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define LPG_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LPG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPG_ASSERT_ALWAYS(lbl, cond, msg)
`define LPG_ASSERT_SAME(lbl, ante, cons, msg)
`define LPG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator package
// Widths, codes and the word types passed between front, queue and back.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS  = 16;
    localparam int COLOR_BITS  = 8;
    // error term spans (2*dmin - 2*dmaj, 2*dmin], two bits above a coordinate
    localparam int ERR_W       = COORD_BITS + 2;
    localparam int STRAIGHT_W  = COORD_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // mode codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] mag_t;
    typedef logic        [COLOR_BITS-1:0] color_t;
    typedef logic signed [ERR_W-1:0]      err_t;
    typedef logic        [STRAIGHT_W-1:0] straight_t;

    // one classified word: a start with its setup, or a tick
    typedef struct packed {
        logic   is_start;
        logic   steep;
        logic   major_neg;
        logic   minor_neg;
        coord_t major_pos;
        coord_t minor_pos;
        coord_t major_stop;
        mag_t   dmaj;
        mag_t   dmin;
        color_t color;
    } queue_entry_t;

    typedef struct packed {
        logic         push;
        queue_entry_t entry;
    } queue_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== sv/lpg_front.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator front end
// Accepts input words, classifies the line (steep or shallow, step signs,
// extents) and pushes the prepared word into the queue.
// ----------------------------------------------------------------------------
module lpg_front
    import lpg_pkg::*;
(
    input  logic          item_valid,
    output logic          item_stall,
    input  logic          mode,
    input  coord_t        start_x,
    input  coord_t        start_y,
    input  coord_t        end_x,
    input  coord_t        end_y,
    input  color_t        color,
    input  queue_status_t q_status,
    output queue_push_t   q_push
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic signed [COORD_BITS:0] dx_neg;
    logic signed [COORD_BITS:0] dy_neg;
    mag_t                       mag_x;
    mag_t                       mag_y;
    logic                       steep;

    // extents and their magnitudes (always below 2^COORD_BITS)
    always_comb
    begin
        dx     = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        dy     = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        dx_neg = -dx;
        dy_neg = -dy;
        mag_x  = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        mag_y  = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        // ties count as steep
        steep  = (mag_y >= mag_x);
    end

    // build the queue word with the axes swapped for steep lines
    always_comb
    begin
        q_push.push           = item_valid && !q_status.full;
        q_push.entry.is_start = (mode == MODE_START);
        q_push.entry.steep    = steep;
        q_push.entry.color    = color;
        if (steep)
        begin
            q_push.entry.major_pos  = start_y;
            q_push.entry.minor_pos  = start_x;
            q_push.entry.major_stop = end_y;
            q_push.entry.major_neg  = dy[COORD_BITS];
            q_push.entry.minor_neg  = dx[COORD_BITS];
            q_push.entry.dmaj       = mag_y;
            q_push.entry.dmin       = mag_x;
        end
        else
        begin
            q_push.entry.major_pos  = start_x;
            q_push.entry.minor_pos  = start_y;
            q_push.entry.major_stop = end_x;
            q_push.entry.major_neg  = dx[COORD_BITS];
            q_push.entry.minor_neg  = dy[COORD_BITS];
            q_push.entry.dmaj       = mag_x;
            q_push.entry.dmin       = mag_y;
        end
    end

    assign item_stall = q_status.full;

endmodule

// ===== sv/lpg_queue.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator word queue
// Short register queue between front and back so each side stalls alone.
// ----------------------------------------------------------------------------
module lpg_queue
    import lpg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_push_t   q_push,
    input  logic          pop,
    output queue_status_t q_status,
    output queue_entry_t  head
);

`include "line_pixel_generator_top_macros.svh"

    queue_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entry_reg[rd_ptr_reg];
    assign do_push        = q_push.push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

    `LPG_ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overrun")
    `LPG_ASSERT_SAME(a_pop_nonempty, pop, !q_status.empty, "pop from empty queue")
    `LPG_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "push lost")

endmodule

// ===== sv/lpg_back.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator back end
// Executes queued words: a start loads the Bresenham state, a tick steps the
// error term and places one pixel in the output register (dropped if idle).
// ----------------------------------------------------------------------------
module lpg_back
    import lpg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  queue_entry_t  head,
    output logic          pop,
    output logic          pixel_valid,
    input  logic          pixel_stall,
    output coord_t        pixel_x,
    output coord_t        pixel_y,
    output color_t        pixel_color,
    output logic          last_pixel
);

`include "line_pixel_generator_top_macros.svh"

    // line state
    logic      busy_reg,       busy_next;
    logic      steep_reg,      steep_next;
    logic      maj_neg_reg,    maj_neg_next;
    logic      min_neg_reg,    min_neg_next;
    coord_t    major_pos_reg,  major_pos_next;
    coord_t    minor_pos_reg,  minor_pos_next;
    coord_t    major_stop_reg, major_stop_next;
    err_t      err_reg,        err_next;
    straight_t straight_reg,   straight_next;
    err_t      diag_reg,       diag_next;
    color_t    color_reg,      color_next;

    // output word
    logic      out_valid_reg,  out_valid_next;
    coord_t    out_x_reg,      out_x_next;
    coord_t    out_y_reg,      out_y_next;
    color_t    out_color_reg,  out_color_next;
    logic      out_last_reg,   out_last_next;

    logic      out_free;
    logic      emit;
    coord_t    major_step;
    coord_t    minor_step;
    logic      last_step;
    err_t      twice_dmin;
    err_t      twice_dmaj;
    err_t      dmaj_ext;

    assign out_free = !out_valid_reg || !pixel_stall;
    assign pop      = !q_status.empty && (head.is_start || !busy_reg || out_free);
    assign emit     = !q_status.empty && !head.is_start && busy_reg && out_free;

    // one Bresenham step along the major axis
    always_comb
    begin
        major_step = maj_neg_reg ? major_pos_reg - COORD_BITS'(1)
                                 : major_pos_reg + COORD_BITS'(1);
        minor_step = min_neg_reg ? minor_pos_reg - COORD_BITS'(1)
                                 : minor_pos_reg + COORD_BITS'(1);
        last_step  = (major_step == major_stop_reg);
        twice_dmin = $signed({1'b0, head.dmin, 1'b0});
        twice_dmaj = $signed({1'b0, head.dmaj, 1'b0});
        dmaj_ext   = $signed({2'b00, head.dmaj});
    end

    // line state next values
    always_comb
    begin
        busy_next       = busy_reg;
        steep_next      = steep_reg;
        maj_neg_next    = maj_neg_reg;
        min_neg_next    = min_neg_reg;
        major_pos_next  = major_pos_reg;
        minor_pos_next  = minor_pos_reg;
        major_stop_next = major_stop_reg;
        err_next        = err_reg;
        straight_next   = straight_reg;
        diag_next       = diag_reg;
        color_next      = color_reg;
        if (pop && head.is_start)
        begin
            steep_next      = head.steep;
            maj_neg_next    = head.major_neg;
            min_neg_next    = head.minor_neg;
            major_pos_next  = head.major_pos;
            minor_pos_next  = head.minor_pos;
            major_stop_next = head.major_stop;
            straight_next   = {head.dmin, 1'b0};
            diag_next       = twice_dmin - twice_dmaj;
            err_next        = twice_dmin - dmaj_ext;
            color_next      = head.color;
            // zero-length line never goes active
            busy_next       = (head.dmaj != '0);
        end
        else if (emit)
        begin
            major_pos_next = major_step;
            if (err_reg > 0)
            begin
                err_next       = err_reg + diag_reg;
                minor_pos_next = minor_step;
            end
            else
            begin
                err_next = err_reg + $signed({1'b0, straight_reg});
            end
            if (last_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg && pixel_stall;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_x_next     = steep_reg ? minor_pos_reg : major_pos_reg;
            out_y_next     = steep_reg ? major_pos_reg : minor_pos_reg;
            out_color_next = color_reg;
            out_last_next  = last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            steep_reg      <= 1'b0;
            maj_neg_reg    <= 1'b0;
            min_neg_reg    <= 1'b0;
            major_pos_reg  <= '0;
            minor_pos_reg  <= '0;
            major_stop_reg <= '0;
            err_reg        <= '0;
            straight_reg   <= '0;
            diag_reg       <= '0;
            color_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            steep_reg      <= steep_next;
            maj_neg_reg    <= maj_neg_next;
            min_neg_reg    <= min_neg_next;
            major_pos_reg  <= major_pos_next;
            minor_pos_reg  <= minor_pos_next;
            major_stop_reg <= major_stop_next;
            err_reg        <= err_next;
            straight_reg   <= straight_next;
            diag_reg       <= diag_next;
            color_reg      <= color_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last_pixel  = out_last_reg;

    `LPG_ASSERT_SAME(a_busy_not_at_stop, busy_reg, major_pos_reg != major_stop_reg, "active line at stop")
    `LPG_ASSERT_NEXT(a_last_ends_line, emit && last_step, !busy_reg, "line still active after last pixel")
    `LPG_ASSERT_SAME(a_emit_slot_free, emit, out_free, "pixel overwrote held word")

endmodule

// ===== sv/line_pixel_generator_top.sv =====
// ----------------------------------------------------------------------------
// Line pixel generator top level
// Bresenham line rasterizer: front classifier, word queue, stepping back end.
// ----------------------------------------------------------------------------
// A tick's pixel passes through the queue register, then the output register.
// Throughput: one word per cycle while pixel_stall is low; a start only loads
// the line state and a tick one error-term add and compare, so pixels stream
// at one per cycle while the output is not stalled.
// Queue of two words decouples input stall from output stall.
// Reset (rst_n low, async): queue empty, no line active, no pixel pending.
module line_pixel_generator_top
    import lpg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  logic   mode,
    input  coord_t start_x,
    input  coord_t start_y,
    input  coord_t end_x,
    input  coord_t end_y,
    input  color_t color,
    output logic   pixel_valid,
    input  logic   pixel_stall,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output color_t pixel_color,
    output logic   last_pixel
);

    queue_push_t   q_push;
    queue_status_t q_status;
    queue_entry_t  head;
    logic          pop;

    lpg_front u_front
    (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .color      (color),
        .q_status   (q_status),
        .q_push     (q_push)
    );

    lpg_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    lpg_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head        (head),
        .pop         (pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule
